[rtl/rgb_framebuffer_engine_defines.svh]
// Assertion macros used by the frame store back end.
`ifndef RGB_FRAMEBUFFER_ENGINE_DEFINES_SVH
`define RGB_FRAMEBUFFER_ENGINE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define RFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define RFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rfe_pkg.sv]
package rfe_pkg;

    localparam int DEF_MAX_WIDTH  = 320;
    localparam int DEF_MAX_HEIGHT = 240;

    // Address field of a queue entry, wide enough for the largest frame.
    localparam int ENTRY_ADDR_W = 25;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] LEVEL_CAP   = 7'd100;
    localparam logic [8:0] RESET_WIDTH = 9'd320;
    localparam logic [7:0] RESET_HEIGHT = 8'd240;

    localparam logic [2:0] KIND_DRAW  = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_FILL  = 3'd2;
    localparam logic [2:0] KIND_LEVEL = 3'd3;
    localparam logic [2:0] KIND_CLEAR = 3'd4;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        OP_DRAW  = 3'd0,
        OP_READ  = 3'd1,
        OP_FILL  = 3'd2,
        OP_LEVEL = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] x_pos;
        logic [7:0] y_pos;
        logic [8:0] rect_width;
        logic [7:0] rect_height;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] new_level;
    } in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       in_range;
    } out_t;

    typedef struct packed {
        op_t                     op;
        logic                    in_range;
        logic [ENTRY_ADDR_W-1:0] addr;
        logic [8:0]              rect_width;
        logic [7:0]              rect_height;
        logic [23:0]             color;
        logic [6:0]              level;
    } entry_t;

    typedef struct packed {
        logic init_busy;
    } status_t;

endpackage

[rtl/rfe_front.sv]
module rfe_front
    import rfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_item,
    input  logic [8:0] eff_w,
    input  logic [7:0] eff_h,
    input  status_t    status,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    in_t         item_reg;
    logic        valid_reg;
    logic        valid_next;
    logic        accept;
    logic        consume;
    logic        drop;
    logic        x_ok;
    logic        y_ok;
    logic        fill_ok;
    logic        is_level;
    logic [7:0]  row;
    logic [16:0] prod;

    always_comb
    begin
        x_ok     = item_reg.x_pos < eff_w;
        y_ok     = item_reg.y_pos < eff_h;
        fill_ok  = ({1'b0, item_reg.x_pos} + {1'b0, item_reg.rect_width} <= {1'b0, eff_w})
                && ({1'b0, item_reg.y_pos} + {1'b0, item_reg.rect_height} <= {1'b0, eff_h})
                && (item_reg.rect_width != 9'd0) && (item_reg.rect_height != 8'd0);
        is_level = item_reg.kind == KIND_LEVEL;
        // Rows are stored bottom-up; a level entry carries the frame area instead.
        row      = is_level ? eff_h : (eff_h - 8'd1 - item_reg.y_pos);
        prod     = {9'd0, row} * {8'd0, eff_w};

        q_entry.op          = OP_DRAW;
        q_entry.in_range    = x_ok && y_ok;
        q_entry.addr        = ENTRY_ADDR_W'(prod)
                            + ENTRY_ADDR_W'(is_level ? 9'd0 : item_reg.x_pos);
        q_entry.rect_width  = item_reg.rect_width;
        q_entry.rect_height = item_reg.rect_height;
        q_entry.color       = {item_reg.in_red, item_reg.in_green, item_reg.in_blue};
        q_entry.level       = (item_reg.new_level > {1'b0, LEVEL_CAP}) ? LEVEL_CAP
                                                                     : item_reg.new_level[6:0];
        drop = 1'b1;
        unique case (item_reg.kind)
            KIND_DRAW:
            begin
                q_entry.op = OP_DRAW;
                drop       = !(x_ok && y_ok);
            end
            KIND_READ:
            begin
                q_entry.op = OP_READ;
                drop       = 1'b0;
            end
            KIND_FILL:
            begin
                q_entry.op = OP_FILL;
                drop       = !fill_ok;
            end
            KIND_LEVEL:
            begin
                q_entry.op = OP_LEVEL;
                drop       = 1'b0;
            end
            KIND_CLEAR:
            begin
                q_entry.op = OP_CLEAR;
                drop       = 1'b0;
            end
            default:
            begin
                q_entry.op = OP_DRAW;
                drop       = 1'b1;
            end
        endcase

        q_push     = valid_reg && !drop && !q_full;
        consume    = valid_reg && (drop || !q_full);
        in_stall   = status.init_busy || (valid_reg && !consume);
        accept     = in_valid && !in_stall;
        valid_next = accept ? 1'b1 : (consume ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[rtl/rfe_queue.sv]
module rfe_queue
    import rfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   empty,
    input  logic   pop,
    output entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        full  = count_reg == CNT_W'(QUEUE_DEPTH);
        empty = count_reg == CNT_W'(0);
        head  = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/rfe_back.sv]
`include "rgb_framebuffer_engine_defines.svh"

module rfe_back
    import rfe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  entry_t  head,
    output logic    q_pop,
    input  logic [8:0] eff_w,
    output status_t status,
    output logic    out_valid,
    input  logic    out_stall,
    output out_t    out_item
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_FILL  = 7'b0000100,
        ST_CLEAR = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_TABLE = 7'b0100000,
        ST_SCALE = 7'b1000000
    } state_t;

    logic [23:0] mem [DEPTH];
    logic [7:0]  tab_r [256];
    logic [7:0]  tab_g [256];
    logic [7:0]  tab_b [256];

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  area_reg, area_next;
    logic [ADDR_W-1:0] pix_reg, pix_next;
    logic [ADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [8:0]        col_reg, col_next;
    logic [8:0]        rw_reg, rw_next;
    logic [7:0]        rows_left_reg, rows_left_next;
    logic [23:0]       color_reg, color_next;
    logic [6:0]        level_reg, level_next;
    logic [6:0]        old_reg, old_next;
    logic [7:0]        rem_reg, rem_next;
    logic [6:0]        quo_reg, quo_next;
    logic [6:0]        dvd_reg, dvd_next;
    logic [2:0]        div_cnt_reg, div_cnt_next;
    logic [7:0]        tab_idx_reg, tab_idx_next;
    logic [14:0]       acc_q_reg, acc_q_next;
    logic [6:0]        acc_r_reg, acc_r_next;
    logic              v1_reg, v1_next, v2_reg;
    logic [ADDR_W-1:0] a1_reg, a2_reg;
    logic              out_valid_reg, out_valid_next;
    out_t              out_item_reg, out_item_next;

    logic [23:0]       mem_rdata_reg;
    logic [7:0]        tab_rd_r_reg, tab_rd_g_reg, tab_rd_b_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [23:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic              tab_we;
    logic [7:0]        tab_wdata;
    logic [7:0]        trial;
    logic [7:0]        sum_r;

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        cnt_next       = cnt_reg;
        area_next      = area_reg;
        pix_next       = pix_reg;
        row_addr_next  = row_addr_reg;
        col_next       = col_reg;
        rw_next        = rw_reg;
        rows_left_next = rows_left_reg;
        color_next     = color_reg;
        level_next     = level_reg;
        old_next       = old_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvd_next       = dvd_reg;
        div_cnt_next   = div_cnt_reg;
        tab_idx_next   = tab_idx_reg;
        acc_q_next     = acc_q_reg;
        acc_r_next     = acc_r_reg;
        v1_next        = 1'b0;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = pix_reg;
        wdata          = color_reg;
        raddr          = head.addr[ADDR_W-1:0];
        tab_we         = 1'b0;
        tab_wdata      = (acc_q_reg > 15'd255) ? 8'd255 : acc_q_reg[7:0];
        trial          = {rem_reg[6:0], dvd_reg[6]};
        sum_r          = {1'b0, acc_r_reg} + {1'b0, rem_reg[6:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && (head.op != OP_READ || !out_valid_reg))
                begin
                    q_pop = 1'b1;
                    unique case (head.op)
                        OP_DRAW:
                        begin
                            we    = 1'b1;
                            waddr = head.addr[ADDR_W-1:0];
                            wdata = head.color;
                        end
                        OP_READ:
                        begin
                            if (head.in_range)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                out_item_next  = '0;
                                out_valid_next = 1'b1;
                            end
                        end
                        OP_FILL:
                        begin
                            pix_next       = head.addr[ADDR_W-1:0];
                            row_addr_next  = head.addr[ADDR_W-1:0];
                            col_next       = 9'd0;
                            rw_next        = head.rect_width;
                            rows_left_next = head.rect_height;
                            color_next     = head.color;
                            state_next     = ST_FILL;
                        end
                        OP_LEVEL:
                        begin
                            level_next = head.level;
                            old_next   = level_reg;
                            area_next  = head.addr[CNT_W-1:0];
                            dvd_next   = head.level;
                            rem_next   = 8'd0;
                            quo_next   = 7'd0;
                            div_cnt_next = 3'd0;
                            if (level_reg != 7'd0 && head.addr[CNT_W-1:0] != CNT_W'(0))
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_item_next  = {mem_rdata_reg, 1'b1};
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_FILL:
            begin
                we = 1'b1;
                if (col_reg == rw_reg - 9'd1)
                begin
                    col_next       = 9'd0;
                    rows_left_next = rows_left_reg - 8'd1;
                    row_addr_next  = row_addr_reg - ADDR_W'(eff_w);
                    pix_next       = row_addr_reg - ADDR_W'(eff_w);
                    if (rows_left_reg == 8'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 9'd1;
                    pix_next = pix_reg + 1'b1;
                end
            end
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[ADDR_W-1:0];
                wdata = 24'h000000;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DEPTH - 1))
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                // Restoring division of the new level by the old one, a bit a cycle.
                if (trial >= {1'b0, old_reg})
                begin
                    rem_next = trial - {1'b0, old_reg};
                    quo_next = {quo_reg[5:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[5:0], 1'b0};
                end
                dvd_next     = {dvd_reg[5:0], 1'b0};
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd6)
                begin
                    tab_idx_next = 8'd0;
                    acc_q_next   = 15'd0;
                    acc_r_next   = 7'd0;
                    state_next   = ST_TABLE;
                end
            end
            ST_TABLE:
            begin
                // Entry c holds floor(c*new/old) capped at 255; stepping c adds new/old with carry.
                tab_we       = 1'b1;
                tab_idx_next = tab_idx_reg + 8'd1;
                if (sum_r >= {1'b0, old_reg})
                begin
                    acc_r_next = 7'(sum_r - {1'b0, old_reg});
                    acc_q_next = acc_q_reg + 15'(quo_reg) + 15'd1;
                end
                else
                begin
                    acc_r_next = sum_r[6:0];
                    acc_q_next = acc_q_reg + 15'(quo_reg);
                end
                if (tab_idx_reg == 8'd255)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                raddr = cnt_reg[ADDR_W-1:0];
                we    = v2_reg;
                waddr = a2_reg;
                wdata = {tab_rd_r_reg, tab_rd_g_reg, tab_rd_b_reg};
                if (cnt_reg != area_reg)
                begin
                    v1_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            level_reg     <= LEVEL_CAP;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            level_reg     <= level_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg      <= area_next;
        pix_reg       <= pix_next;
        row_addr_reg  <= row_addr_next;
        col_reg       <= col_next;
        rw_reg        <= rw_next;
        rows_left_reg <= rows_left_next;
        color_reg     <= color_next;
        old_reg       <= old_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvd_reg       <= dvd_next;
        div_cnt_reg   <= div_cnt_next;
        tab_idx_reg   <= tab_idx_next;
        acc_q_reg     <= acc_q_next;
        acc_r_reg     <= acc_r_next;
        a1_reg        <= cnt_reg[ADDR_W-1:0];
        a2_reg        <= a1_reg;
        out_item_reg  <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_r[tab_idx_reg] <= tab_wdata;
            tab_g[tab_idx_reg] <= tab_wdata;
            tab_b[tab_idx_reg] <= tab_wdata;
        end
        tab_rd_r_reg <= tab_r[mem_rdata_reg[23:16]];
        tab_rd_g_reg <= tab_g[mem_rdata_reg[15:8]];
        tab_rd_b_reg <= tab_b[mem_rdata_reg[7:0]];
    end

    assign status.init_busy = init_reg;
    assign out_valid        = out_valid_reg;
    assign out_item         = out_item_reg;

    `RFE_ASSERT_NOW(a_read_slot_free, q_pop && head.op == OP_READ, !out_valid_reg, "read taken while result slot busy")
    `RFE_ASSERT_NEXT(a_read_delivers, state_reg == ST_READ, out_valid_reg, "read data not presented")
    `RFE_ASSERT_NOW(a_init_in_clear, init_reg, state_reg == ST_CLEAR, "init pass left clear state")
    `RFE_ASSERT_NOW(a_scale_pipe, v2_reg, state_reg == ST_SCALE, "rescale write outside sweep")

endmodule

[rtl/rgb_framebuffer_engine.sv]
// RGB 8-8-8 frame store with draw, read, rectangle fill, brightness rescale
// and clear commands.
// Commands arrive on the in channel (in_valid/in_stall, in_item); a beat is
// taken when in_valid is high and in_stall low. Only read commands produce a
// result beat on the out channel (out_valid/out_stall, out_item), which holds
// until the receiver drops out_stall. Frame width and height are written on
// the cfg channel (cfg_valid/cfg_ready, always ready), by the user only while
// the block is idle; the block itself does not enforce this. A front stage
// classifies each command and computes its store address, then hands it
// through a two-entry queue to the back end that owns the memory. Front stage:
// one command per cycle while the queue has room and the reset clear pass is
// over. The back end takes queue commands one at a time: a draw is written as
// it is taken, an in-frame read passes through ST_READ, a fill writes the
// width*height pixels, a clear the whole store (MAX_WIDTH*MAX_HEIGHT), and a
// set-level runs 7 divide steps, 256 table entries and a rescale sweep over
// width*height pixels (none of these when the old level is zero or the frame
// is empty), the store's single read and write port setting the pace. After
// reset the back end clears the store, one pixel a cycle, and in_stall stays
// high during that pass. When out_stall is held, further reads wait in the
// queue and the front stalls once the queue fills.
module rgb_framebuffer_engine
    import rfe_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    logic [8:0] width_reg;
    logic [7:0] height_reg;
    logic [8:0] eff_w;
    logic [7:0] eff_h;
    status_t    status;
    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    entry_t     q_entry;
    entry_t     q_head;

    // Register values are capped at the store's dimensions.
    assign eff_w     = (32'(width_reg) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_reg;
    assign eff_h     = (32'(height_reg) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data[7:0];
            end
        end
    end

    rfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .status   (status),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    rfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .empty      (q_empty),
        .pop        (q_pop),
        .head       (q_head)
    );

    rfe_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (q_head),
        .q_pop     (q_pop),
        .eff_w     (eff_w),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

[verif/rgb_framebuffer_engine_tb.sv]
`timescale 1ns / 100ps

module rgb_framebuffer_engine_tb;
    import rfe_pkg::*;

    // Spare configuration indexes; the block must ignore writes to them.
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;
    // Command kinds beyond clear are ignored and must not produce a beat.
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int PHASE_ITEMS = 170;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_t        in_item;
    logic       out_valid;
    logic       out_stall;
    out_t       out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    rgb_framebuffer_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the frame store and its registers, kept in step with accepted beats.
    logic [23:0] shadow_pixels [0:STORE_DEPTH-1];
    int unsigned shadow_level;
    int unsigned shadow_width_reg;
    int unsigned shadow_height_reg;

    in_t  pending_cmds[$];
    out_t expected_pixels[$];
    int   error_count;
    bit   quiet;
    bit   took_beat;
    int   send_gap;
    int   stall_left;

    always #4 clk = ~clk;

    function automatic int unsigned active_width();
        return (shadow_width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : shadow_width_reg;
    endfunction

    function automatic int unsigned active_height();
        return (shadow_height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : shadow_height_reg;
    endfunction

    // Rows are stored bottom-up, so row y of the picture sits at row (H-1-y).
    function automatic int unsigned pixel_addr(int unsigned x, int unsigned y,
                                               int unsigned w, int unsigned h);
        int unsigned a;
        a = (h - 1 - y) * w + x;
        return (a < STORE_DEPTH) ? a : 0;
    endfunction

    function automatic logic [7:0] rescale_channel(logic [7:0] c, int unsigned nl,
                                                   int unsigned ol);
        int unsigned v;
        v = (c * nl) / ol;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Applies one accepted command to the shadow store and, for a read, queues the expected beat.
    task automatic predict_framebuffer(in_t c);
        int unsigned w;
        int unsigned h;
        int unsigned a;
        int unsigned nl;
        int unsigned ol;
        logic [23:0] color;
        logic [23:0] p;
        out_t r;
        w = active_width();
        h = active_height();
        color = {c.in_red, c.in_green, c.in_blue};
        case (c.kind)
            OP_DRAW:
                if (c.x_pos < w && c.y_pos < h)
                    shadow_pixels[pixel_addr(c.x_pos, c.y_pos, w, h)] = color;
            OP_READ:
            begin
                if (c.x_pos < w && c.y_pos < h) begin
                    p = shadow_pixels[pixel_addr(c.x_pos, c.y_pos, w, h)];
                    r = {p, 1'b1};
                end
                else
                    r = '0;
                expected_pixels.push_back(r);
            end
            OP_FILL:
                if (c.x_pos + c.rect_width <= w && c.y_pos + c.rect_height <= h)
                    for (int i = 0; i < c.rect_height; i++)
                        for (int j = 0; j < c.rect_width; j++)
                            shadow_pixels[pixel_addr(c.x_pos + j, c.y_pos + i, w, h)] = color;
            OP_LEVEL:
            begin
                ol = shadow_level;
                nl = (c.new_level > LEVEL_CAP) ? LEVEL_CAP : c.new_level;
                shadow_level = nl;
                // An old level of zero leaves the pixels alone.
                if (ol != 0)
                    for (int i = 0; i < h; i++)
                        for (int j = 0; j < w; j++) begin
                            a = pixel_addr(j, i, w, h);
                            p = shadow_pixels[a];
                            shadow_pixels[a] = {rescale_channel(p[23:16], nl, ol),
                                                rescale_channel(p[15:8], nl, ol),
                                                rescale_channel(p[7:0], nl, ol)};
                        end
            end
            OP_CLEAR:
                for (int i = 0; i < STORE_DEPTH; i++)
                    shadow_pixels[i] = '0;
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic in_t make_cmd(logic [2:0] kind, int x, int y, int rw, int rh,
                                     logic [23:0] color, int lvl);
        in_t c;
        c.kind = kind;
        c.x_pos = 9'(x);
        c.y_pos = 8'(y);
        c.rect_width = 9'(rw);
        c.rect_height = 8'(rh);
        {c.in_red, c.in_green, c.in_blue} = color;
        c.new_level = 8'(lvl);
        return c;
    endfunction

    // Random command for the current frame. Most beats land inside the frame;
    // the rest carry raw field values. Rescales only run on small frames, since
    // each one walks the whole active frame.
    function automatic in_t random_cmd();
        in_t c;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        w = active_width();
        h = active_height();
        c = {5'($urandom), $urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.kind = OP_DRAW;
        else if (pick < 80)
            c.kind = OP_READ;
        else if (pick < 93)
            c.kind = OP_FILL;
        else if (pick < 96 && w * h <= 4096)
            c.kind = OP_LEVEL;
        else if (pick < 98)
            c.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        else
            c.kind = OP_READ;
        if ($urandom_range(0, 9) < 8 && w > 0 && h > 0) begin
            c.x_pos = 9'($urandom_range(0, w - 1));
            c.y_pos = 8'($urandom_range(0, h - 1));
            c.rect_width = 9'($urandom_range(0, 8));
            c.rect_height = 8'($urandom_range(0, 8));
        end
        // Keep in-frame fills small so the run stays short.
        if (c.kind == OP_FILL && c.x_pos + c.rect_width <= w && c.y_pos + c.rect_height <= h
            && c.rect_width * c.rect_height > 256)
            c.rect_height = 8'd1;
        return c;
    endfunction

    // Waits until every queued beat is taken and every read beat is back. The
    // trailing read makes sure the back end has finished earlier long commands.
    task automatic drain_block();
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 24'h0, 0));
        while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = 9'(value);
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_FRAME_WIDTH)
            shadow_width_reg = value & 9'h1FF;
        else if (idx == CFG_FRAME_HEIGHT)
            shadow_height_reg = value & 8'hFF;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Sender: a beat holds until taken, then the next one is loaded, sometimes
    // after an idle burst.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || took_beat)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0) begin
                in_item <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        took_beat <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            predict_framebuffer(in_item);
    end

    // Receiver: stall in random bursts.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 15);
        end
    end

    // Each read beat is compared with the oldest expected pixel.
    always @(posedge clk) begin
        out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else begin
                want = expected_pixels.pop_front();
                if (out_item.out_red !== want.out_red)
                    report_mismatch("out_red", out_item.out_red, want.out_red);
                if (out_item.out_green !== want.out_green)
                    report_mismatch("out_green", out_item.out_green, want.out_green);
                if (out_item.out_blue !== want.out_blue)
                    report_mismatch("out_blue", out_item.out_blue, want.out_blue);
                if (out_item.in_range !== want.in_range)
                    report_mismatch("in_range", out_item.in_range, want.in_range);
            end
        end
    end

    initial begin
        int phase_w [9] = '{1, 0, 7, 511, 12, 320, 2, 33, 5};
        int phase_h [9] = '{1, 5, 0, 255, 9, 3, 240, 17, 4};
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_data = '0;
        error_count = 0;
        quiet = 1'b0;
        took_beat = 1'b0;
        send_gap = 0;
        stall_left = 0;
        shadow_level = LEVEL_CAP;
        shadow_width_reg = RESET_WIDTH;
        shadow_height_reg = RESET_HEIGHT;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_pixels[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The block clears its store after reset and stalls meanwhile.
        while (in_stall)
            @(negedge clk);

        // Full-size frame, written explicitly.
        write_register(CFG_FRAME_WIDTH, 320);
        write_register(CFG_FRAME_HEIGHT, 240);

        // Directed part: corners, out-of-frame access, full-frame, corner, empty and
        // overrunning fills, level clamp, rescale through zero, and clear.
        pending_cmds.push_back(make_cmd(OP_DRAW, 0, 0, 0, 0, 24'hFFFFFF, 0));
        pending_cmds.push_back(make_cmd(OP_DRAW, 319, 239, 0, 0, 24'h123456, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 319, 239, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_DRAW, 511, 255, 0, 0, 24'hABCDEF, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 511, 255, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 320, 0, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_FILL, 0, 0, 320, 240, 24'h80C040, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 160, 120, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_FILL, 300, 0, 21, 1, 24'hFFFFFF, 0));
        pending_cmds.push_back(make_cmd(OP_FILL, 0, 200, 1, 41, 24'hFFFFFF, 0));
        pending_cmds.push_back(make_cmd(OP_FILL, 10, 10, 0, 5, 24'h00FF00, 0));
        pending_cmds.push_back(make_cmd(OP_FILL, 316, 236, 4, 4, 24'h0000FF, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 319, 239, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_LEVEL, 0, 0, 0, 0, 24'h0, 255));
        pending_cmds.push_back(make_cmd(OP_LEVEL, 0, 0, 0, 0, 24'h0, 50));
        pending_cmds.push_back(make_cmd(OP_READ, 160, 120, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_LEVEL, 0, 0, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_LEVEL, 0, 0, 0, 0, 24'h0, 80));
        pending_cmds.push_back(make_cmd(OP_DRAW, 5, 5, 0, 0, 24'h646464, 0));
        pending_cmds.push_back(make_cmd(KIND_UNUSED_LO, 5, 5, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(KIND_UNUSED_HI, 5, 5, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 5, 5, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 24'h0, 0));
        pending_cmds.push_back(make_cmd(OP_READ, 5, 5, 0, 0, 24'h0, 0));
        // The test waits here until every beat is taken and every read beat has come back.
        drain_block();

        // Random phases over a range of frame shapes, including empty and
        // oversized frames. The last phase runs without idling.
        for (int ph = 0; ph < 9; ph++) begin
            write_register(CFG_FRAME_WIDTH, phase_w[ph]);
            write_register(CFG_FRAME_HEIGHT, phase_h[ph]);
            if (ph % 3 == 0)
                write_register(2'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                               $urandom_range(0, 511));
            quiet = (ph == 8);
            if (ph == 4)
                pending_cmds.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 24'h0, 0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                @(negedge clk);
                pending_cmds.push_back(random_cmd());
                while (pending_cmds.size() > 8)
                    @(negedge clk);
            end
            drain_block();
        end

        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
